// File: sv/lc3b_pkg.sv
// ----------------------------------------------------------------------------
// lc3b_pkg
// Shared types and constants for the LC-3b execute core.
// ----------------------------------------------------------------------------
package lc3b_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_AW    = 3;
  localparam int XLEN      = 16;

  localparam logic [3:0] OP_BR  = 4'h0;
  localparam logic [3:0] OP_ADD = 4'h1;
  localparam logic [3:0] OP_AND = 4'h5;
  localparam logic [3:0] OP_XOR = 4'h9;
  localparam logic [3:0] OP_SHF = 4'hD;

  localparam logic [1:0] SHF_LSHF  = 2'b00;
  localparam logic [1:0] SHF_RSHFL = 2'b01;

  // condition codes: bit 2 N, bit 1 Z, bit 0 P
  localparam logic [2:0] CC_RESET = 3'b010;
  localparam logic [2:0] CC_N     = 3'b100;
  localparam logic [2:0] CC_Z     = 3'b010;
  localparam logic [2:0] CC_P     = 3'b001;

  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic              we;
    logic [REG_AW-1:0] dr;
    logic [XLEN-1:0]   value;
    logic [2:0]        cc;
  } exec_res_t;

endpackage

// File: sv/lc3b_ram.sv
// ----------------------------------------------------------------------------
// lc3b_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lc3b_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/lc3b_exec.sv
// ----------------------------------------------------------------------------
// lc3b_exec
// ALU, shifter and branch unit: computes next pc, register write and codes.
// ----------------------------------------------------------------------------
module lc3b_exec (
  input  logic [15:0]         instr,
  input  logic [15:0]         pc_cur,
  input  logic [2:0]          cc_cur,
  input  logic [15:0]         src_a,
  input  logic [15:0]         src_b_reg,
  output lc3b_pkg::exec_res_t res
);

  logic [3:0]  opcode;
  logic [15:0] src_b;
  logic [15:0] pc_inc;
  logic [15:0] br_off;
  logic [15:0] alu_out;
  logic        alu_we;
  logic        br_taken;
  logic [1:0]  shf_sel;
  logic [3:0]  shf_amt;

  assign opcode  = instr[15:12];
  assign shf_sel = instr[5:4];
  assign shf_amt = instr[3:0];
  assign src_b   = instr[5] ? {{11{instr[4]}}, instr[4:0]} : src_b_reg;
  assign pc_inc  = pc_cur + 16'd2;
  // 9-bit word offset scaled to bytes
  assign br_off  = {{6{instr[8]}}, instr[8:0], 1'b0};
  assign br_taken = (opcode == lc3b_pkg::OP_BR) && ((instr[11:9] & cc_cur) != 3'b000);

  always_comb begin
    alu_out = 16'd0;
    alu_we  = 1'b0;
    unique case (opcode)
      lc3b_pkg::OP_ADD: begin
        alu_out = src_a + src_b;
        alu_we  = 1'b1;
      end
      lc3b_pkg::OP_AND: begin
        alu_out = src_a & src_b;
        alu_we  = 1'b1;
      end
      lc3b_pkg::OP_XOR: begin
        alu_out = src_a ^ src_b;
        alu_we  = 1'b1;
      end
      lc3b_pkg::OP_SHF: begin
        alu_we = 1'b1;
        unique case (shf_sel)
          lc3b_pkg::SHF_LSHF:  alu_out = src_a << shf_amt;
          lc3b_pkg::SHF_RSHFL: alu_out = src_a >> shf_amt;
          default:             alu_out = 16'($signed(src_a) >>> shf_amt);
        endcase
      end
      default: begin
        alu_out = 16'd0;
        alu_we  = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.next_pc = 16'd0;
    res.we      = 1'b0;
    res.dr      = '0;
    res.value   = 16'd0;
    res.cc      = cc_cur;
    // a zero pc means the machine is halted: the word is ignored
    if (pc_cur != 16'd0) begin
      res.next_pc = br_taken ? (pc_inc + br_off) : pc_inc;
      if (alu_we) begin
        res.we    = 1'b1;
        res.dr    = instr[11:9];
        res.value = alu_out;
        priority if (alu_out == 16'd0) begin
          res.cc = lc3b_pkg::CC_Z;
        end else if (alu_out[15]) begin
          res.cc = lc3b_pkg::CC_N;
        end else begin
          res.cc = lc3b_pkg::CC_P;
        end
      end
    end
  end

endmodule

// File: sv/lc3b_alu_branch_core_unit.sv
// ----------------------------------------------------------------------------
// lc3b_alu_branch_core_unit
// LC-3b execute core: register file in RAM, ALU, shifter, branch and pc.
// ----------------------------------------------------------------------------
// One instruction beat is taken every clock unless the output stalls. The
// source registers are read from two synchronous register-file RAM copies in
// the accept cycle; the instruction executes from the stage-1 register once
// the output register is free, writing the RAM and the pc/condition codes;
// the last write is forwarded so back-to-back dependent instructions see
// fresh data. Unwritten registers read as zero through per-register valid
// bits cleared by reset. start_address is sampled at the first instruction
// after reset; a pc of zero means halted and further words are ignored.
module lc3b_alu_branch_core_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_next_pc,
  output logic        out_write_enable,
  output logic [2:0]  out_dest_index,
  output logic [15:0] out_write_value,
  output logic        out_flag_negative,
  output logic        out_flag_zero,
  output logic        out_flag_positive,
  output logic        out_halted
);

  localparam int RC = lc3b_pkg::REG_COUNT;
  localparam int AW = lc3b_pkg::REG_AW;

  logic [15:0]         start_r;
  logic [15:0]         pc_r;
  logic [2:0]          cc_r;
  logic                started_r;
  logic [RC-1:0]       rf_valid_r;

  logic                s1_valid_r;
  logic [15:0]         s1_instr_r;

  logic                lw_valid_r;
  logic [AW-1:0]       lw_addr_r;
  logic [15:0]         lw_data_r;

  logic                out_valid_r;
  logic [15:0]         out_next_pc_r;
  logic                out_we_r;
  logic [AW-1:0]       out_dr_r;
  logic [15:0]         out_value_r;
  logic [2:0]          out_cc_r;

  logic                in_accept;
  logic                advance;
  logic [15:0]         rd_a;
  logic [15:0]         rd_b;
  logic [AW-1:0]       s1_sr1;
  logic [AW-1:0]       s1_sr2;
  logic [15:0]         src_a;
  logic [15:0]         src_b;
  logic [15:0]         pc_cur;
  lc3b_pkg::exec_res_t res;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  lc3b_ram #(.WIDTH(16), .DEPTH(RC)) u_rf_a (
    .clk     (clk),
    .wr_en   (advance && res.we),
    .wr_addr (res.dr),
    .wr_data (res.value),
    .rd_en   (in_accept),
    .rd_addr (in_instruction[8:6]),
    .rd_data (rd_a)
  );

  lc3b_ram #(.WIDTH(16), .DEPTH(RC)) u_rf_b (
    .clk     (clk),
    .wr_en   (advance && res.we),
    .wr_addr (res.dr),
    .wr_data (res.value),
    .rd_en   (in_accept),
    .rd_addr (in_instruction[2:0]),
    .rd_data (rd_b)
  );

  assign s1_sr1 = s1_instr_r[8:6];
  assign s1_sr2 = s1_instr_r[2:0];

  // forward the write made at the same edge as the read
  always_comb begin
    priority if (lw_valid_r && (lw_addr_r == s1_sr1)) begin
      src_a = lw_data_r;
    end else if (rf_valid_r[s1_sr1]) begin
      src_a = rd_a;
    end else begin
      src_a = 16'd0;
    end
    priority if (lw_valid_r && (lw_addr_r == s1_sr2)) begin
      src_b = lw_data_r;
    end else if (rf_valid_r[s1_sr2]) begin
      src_b = rd_b;
    end else begin
      src_b = 16'd0;
    end
  end

  assign pc_cur = started_r ? pc_r : start_r;

  lc3b_exec u_exec (
    .instr     (s1_instr_r),
    .pc_cur    (pc_cur),
    .cc_cur    (cc_r),
    .src_a     (src_a),
    .src_b_reg (src_b),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= 16'd0;
      pc_r        <= 16'd0;
      cc_r        <= lc3b_pkg::CC_RESET;
      started_r   <= 1'b0;
      rf_valid_r  <= '0;
      s1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        pc_r        <= res.next_pc;
        cc_r        <= res.cc;
        started_r   <= 1'b1;
        out_valid_r <= 1'b1;
        if (res.we) begin
          rf_valid_r[res.dr] <= 1'b1;
          lw_valid_r         <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_instr_r <= in_instruction;
    end
    if (advance) begin
      out_next_pc_r <= res.next_pc;
      out_we_r      <= res.we;
      out_dr_r      <= res.dr;
      out_value_r   <= res.value;
      out_cc_r      <= res.cc;
      if (res.we) begin
        lw_addr_r <= res.dr;
        lw_data_r <= res.value;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_next_pc_r;
  assign out_write_enable  = out_we_r;
  assign out_dest_index    = out_dr_r;
  assign out_write_value   = out_value_r;
  assign out_flag_negative = out_cc_r[2];
  assign out_flag_zero     = out_cc_r[1];
  assign out_flag_positive = out_cc_r[0];
  assign out_halted        = (out_next_pc_r == 16'd0);

endmodule

// File: verif/lc3b_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3b_exec_checker
// Watches the instruction and result channels of the LC-3b execute core,
// runs its own copy of the machine state on every accepted instruction beat
// and compares each result beat, field by field, against the oldest
// predicted retirement. Mismatch count and outstanding beats go to the top.
// ----------------------------------------------------------------------------
module lc3b_exec_checker
  import lc3b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] in_instruction,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_next_pc,
  input  logic        out_write_enable,
  input  logic [2:0]  out_dest_index,
  input  logic [15:0] out_write_value,
  input  logic        out_flag_negative,
  input  logic        out_flag_zero,
  input  logic        out_flag_positive,
  input  logic        out_halted,
  output int          mismatches,
  output int          outstanding,
  output logic [15:0] model_pc
);

  typedef struct packed {
    logic [15:0] next_pc;
    logic        we;
    logic [2:0]  dr;
    logic [15:0] value;
    logic [2:0]  cc;
    logic        halted;
  } retire_t;

  logic [15:0] gpr [REG_COUNT];
  logic [15:0] boot_pc;
  logic [2:0]  cc;
  logic        running;
  retire_t     retire_q[$];

  function automatic logic [2:0] codes_for(input logic [15:0] v);
    if (v == 16'h0000) return CC_Z;
    return v[15] ? CC_N : CC_P;
  endfunction

  // one instruction through the machine, state updated in place
  task automatic execute_word(input logic [15:0] w, output retire_t r);
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] res;
    logic [31:0] ext;
    logic        we;
    res = '0;
    we  = 1'b0;
    if (!running) begin
      model_pc = boot_pc;
      running  = 1'b1;
    end
    // pc of zero means halted: the word is dropped
    if (model_pc != 16'h0000) begin
      model_pc = model_pc + 16'd2;
      a = gpr[w[8:6]];
      b = w[5] ? {{11{w[4]}}, w[4:0]} : gpr[w[2:0]];
      case (w[15:12])
        OP_ADD: begin
          res = a + b;
          we  = 1'b1;
        end
        OP_AND: begin
          res = a & b;
          we  = 1'b1;
        end
        OP_XOR: begin
          res = a ^ b;
          we  = 1'b1;
        end
        OP_SHF: begin
          if (w[5:4] == SHF_LSHF) begin
            res = a << w[3:0];
          end else if (w[5:4] == SHF_RSHFL) begin
            res = a >> w[3:0];
          end else begin
            ext = {{16{a[15]}}, a} >> w[3:0];
            res = ext[15:0];
          end
          we = 1'b1;
        end
        OP_BR: begin
          if ((w[11:9] & cc) != 3'b000) model_pc = model_pc + {{6{w[8]}}, w[8:0], 1'b0};
        end
        default: ;
      endcase
      if (we) begin
        gpr[w[11:9]] = res;
        cc = codes_for(res);
      end
    end
    r.next_pc = model_pc;
    r.we      = we;
    r.dr      = we ? w[11:9] : 3'd0;
    r.value   = res;
    r.cc      = cc;
    r.halted  = (model_pc == 16'h0000);
  endtask

  always @(posedge clk) begin : monitor
    retire_t want;
    retire_t got;
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
      boot_pc    = '0;
      cc         = CC_RESET;
      running    = 1'b0;
      model_pc   = '0;
      mismatches = 0;
      retire_q.delete();
    end else begin
      if (cfg_we) boot_pc = cfg_wdata;
      if (in_valid && in_ready) begin
        execute_word(in_instruction, want);
        retire_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_next_pc, out_write_enable, out_dest_index, out_write_value,
               out_flag_negative, out_flag_zero, out_flag_positive, out_halted};
        if (retire_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing outstanding: %s",
                     $realtime,
                     $sformatf("pc=%h we=%b dr=%0d val=%h cc=%b halt=%b",
                               got.next_pc, got.we, got.dr, got.value, got.cc,
                               got.halted));
        end else begin
          want = retire_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result differs: exp %s, got %s",
                       $realtime,
                       $sformatf("pc=%h we=%b dr=%0d val=%h cc=%b halt=%b",
                                 want.next_pc, want.we, want.dr, want.value,
                                 want.cc, want.halted),
                       $sformatf("pc=%h we=%b dr=%0d val=%h cc=%b halt=%b",
                                 got.next_pc, got.we, got.dr, got.value,
                                 got.cc, got.halted));
          end
        end
      end
    end
    outstanding = retire_q.size();
  end

endmodule

// File: verif/tb_lc3b_alu_branch_core_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lc3b_alu_branch_core_unit
// Drives instruction beats into the LC-3b execute core: a directed sweep of
// operand extremes, each executed opcode and shift selector, branches, then
// random programs, then a walk of the pc onto zero to check the halted state.
// The checker beside the block does the prediction; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_lc3b_alu_branch_core_unit;
  import lc3b_pkg::*;

  // opcodes the core does not execute
  localparam logic [3:0] OP_LDB    = 4'h2;
  localparam logic [3:0] OP_RTI    = 4'h8;
  localparam logic [3:0] OP_UNUSED = 4'hA;
  localparam logic [3:0] OP_JMP    = 4'hC;
  localparam logic [3:0] OP_TRAP   = 4'hF;

  localparam logic [1:0] SHF_RSHFA     = 2'b10;
  localparam logic [1:0] SHF_RSHFA_ALT = 2'b11;

  localparam logic [15:0] BOOT_PC     = 16'h8000;
  localparam int          RAND_WORDS  = 2000;
  localparam int          STALL_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_instruction;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_next_pc;
  logic        out_write_enable;
  logic [2:0]  out_dest_index;
  logic [15:0] out_write_value;
  logic        out_flag_negative;
  logic        out_flag_zero;
  logic        out_flag_positive;
  logic        out_halted;

  int          mismatches;
  int          outstanding;
  logic [15:0] model_pc;
  int          burst_left;
  int          quiet_cycles;

  lc3b_alu_branch_core_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_instruction    (in_instruction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_pc       (out_next_pc),
    .out_write_enable  (out_write_enable),
    .out_dest_index    (out_dest_index),
    .out_write_value   (out_write_value),
    .out_flag_negative (out_flag_negative),
    .out_flag_zero     (out_flag_zero),
    .out_flag_positive (out_flag_positive),
    .out_halted        (out_halted)
  );

  lc3b_exec_checker u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_instruction    (in_instruction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_pc       (out_next_pc),
    .out_write_enable  (out_write_enable),
    .out_dest_index    (out_dest_index),
    .out_write_value   (out_write_value),
    .out_flag_negative (out_flag_negative),
    .out_flag_zero     (out_flag_zero),
    .out_flag_positive (out_flag_positive),
    .out_halted        (out_halted),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .model_pc          (model_pc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] alu_word(input logic [3:0] op, input logic [2:0] dr,
                                           input logic [2:0] sr1, input logic imm,
                                           input logic [4:0] low);
    return {op, dr, sr1, imm, low};
  endfunction

  function automatic logic [15:0] shf_word(input logic [2:0] dr, input logic [2:0] sr,
                                           input logic [1:0] sel, input logic [3:0] amt);
    return {OP_SHF, dr, sr, sel, amt};
  endfunction

  function automatic logic [15:0] br_word(input logic [2:0] nzp, input logic [8:0] off);
    return {OP_BR, nzp, off};
  endfunction

  // mostly executable opcodes with random fields, some raw words
  function automatic logic [15:0] rand_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return {OP_ADD, 12'($urandom)};
    if (pick < 45) return {OP_AND, 12'($urandom)};
    if (pick < 60) return {OP_XOR, 12'($urandom)};
    if (pick < 75) return {OP_SHF, 12'($urandom)};
    if (pick < 90) return {OP_BR, 12'($urandom)};
    return 16'($urandom);
  endfunction

  task automatic idle_gap(input int n);
    repeat (n) @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic push_word(input logic [15:0] w);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_instruction <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // bursts of random length with random gaps, some gaps zero
  task automatic send_paced(input logic [15:0] w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    burst_left--;
    push_word(w);
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start(input logic [15:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  // receiver: segments of different stall density, a long hold-off now and then
  initial begin
    int seg;
    int len;
    int pct;
    out_ready = 1'b0;
    seg = 0;
    wait (rst_n);
    forever begin
      if (seg % 25 == 8) begin
        repeat (300) @(negedge clk) out_ready <= 1'b0;
      end else begin
        len = $urandom_range(10, 80);
        case ($urandom_range(0, 2))
          0:       pct = 100;
          1:       pct = 60;
          default: pct = 25;
        endcase
        repeat (len) @(negedge clk) out_ready <= ($urandom_range(0, 99) < pct);
      end
      seg++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("lc3b_alu_branch_core_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [15:0] pc_gap;
    int          pc_left;
    int          step;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_instruction = '0;
    burst_left     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // last write before the first beat sets the boot pc
    write_start(16'hFFFE);
    write_start(16'h0000);
    write_start(BOOT_PC);

    send_paced(alu_word(OP_ADD, 3'd1, 3'd0, 1'b1, 5'h0F));
    send_paced(alu_word(OP_ADD, 3'd2, 3'd0, 1'b1, 5'h10));
    send_paced(alu_word(OP_ADD, 3'd3, 3'd1, 1'b0, 5'd2));
    send_paced(alu_word(OP_AND, 3'd4, 3'd3, 1'b0, 5'd1));
    send_paced(alu_word(OP_AND, 3'd5, 3'd1, 1'b1, 5'h00));
    send_paced(br_word(CC_Z, 9'h004));
    send_paced(alu_word(OP_XOR, 3'd6, 3'd1, 1'b1, 5'h1F));
    send_paced(alu_word(OP_XOR, 3'd7, 3'd3, 1'b0, 5'd2));
    send_paced(shf_word(3'd1, 3'd3, SHF_LSHF, 4'd0));
    send_paced(shf_word(3'd1, 3'd1, SHF_LSHF, 4'd15));
    send_paced(shf_word(3'd2, 3'd1, SHF_RSHFL, 4'd15));
    send_paced(shf_word(3'd0, 3'd1, SHF_RSHFL, 4'd0));
    send_paced(shf_word(3'd3, 3'd1, SHF_RSHFA, 4'd15));
    send_paced(shf_word(3'd4, 3'd1, SHF_RSHFA_ALT, 4'd3));
    // nzp of zero never branches
    send_paced(br_word(3'b000, 9'h1FF));
    send_paced(br_word(CC_Z | CC_P, 9'h0FF));
    send_paced(br_word(CC_N, 9'h100));
    send_paced(br_word(CC_N | CC_Z | CC_P, 9'h0FF));
    send_paced(alu_word(OP_ADD, 3'd7, 3'd7, 1'b0, 5'd7));
    send_paced({OP_LDB, 12'hFFF});
    send_paced({OP_TRAP, 12'h025});
    send_paced({OP_RTI, 12'h000});
    send_paced({OP_UNUSED, 12'hABC});
    send_paced({OP_JMP, 12'h1C0});
    wait_drained();

    // late boot pc write, must not move the running pc
    write_start(16'hFFFE);
    for (int i = 0; i < RAND_WORDS; i++) send_paced(rand_word());
    wait_drained();
    write_start(16'h0000);

    // always-taken branches walk the pc onto zero, then words are dropped
    pc_gap  = 16'h0000 - model_pc;
    pc_left = pc_gap;
    while (pc_left >= 2) begin
      step = (pc_left >= 514) ? 512 : pc_left;
      send_paced(br_word(CC_N | CC_Z | CC_P, 9'((step - 2) / 2)));
      pc_left -= step;
    end
    for (int i = 0; i < 12; i++) send_paced(rand_word());

    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("lc3b_alu_branch_core_unit: match");
    end else begin
      $display("lc3b_alu_branch_core_unit: mismatch");
    end
    $finish;
  end

endmodule
